### hw/rtl/stlu_pkg.sv
`timescale 1ns / 1ps
package stlu_pkg;
  localparam int NUM_TIMERS_DEF = 64;
  localparam int MAX_TIMERS = 64;
  localparam logic [31:0] ALL_ONES = 32'hffffffff;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ALLOC  = 3'd1,
    ACT_FREE   = 3'd2,
    ACT_INIT   = 3'd3,
    ACT_SET    = 3'd4,
    ACT_CANCEL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_EXP  = 2'd1,
    KIND_TASK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_RUN  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  localparam logic [0:0] REG_TASK_INDEX  = 1'd0;
  localparam logic [0:0] REG_TASK_ENABLE = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [31:0] data;
    logic [7:0]  owner;
    logic [1:0]  status;
    logic        last;
  } result_t;
endpackage

### hw/rtl/stlu_out_reg.sv
`timescale 1ns / 1ps
module stlu_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stlu_pkg::result_t push_beat,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output stlu_pkg::result_t out_beat
);
  logic              valid_r;
  stlu_pkg::result_t beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      beat_r <= push_beat;
    end
  end

  assign full      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;
endmodule

### hw/rtl/sorted_timer_list_unit_top.sv
`timescale 1ns / 1ps
// Pool of one-shot timers kept in a singly linked list sorted by expiry time.
// The entry fields (mode, app mark, owner, tag, expiry, link) live in one
// synchronous memory with a registered read port; a sequencer reads, updates
// and writes back one entry at a time. Allocate and cancel-all scan the
// pool; set, cancel and free walk the list; a tick delivers expiry beats
// while the output is not stalled. Cancel-all can reach NUM_TIMERS list
// walks. Results leave through one output register, so the block keeps
// working while a beat waits, until it has another beat to push.
// After reset a clearing pass over all NUM_TIMERS entries resets every
// entry's mode before the first beat is accepted.
module sorted_timer_list_unit_top #(
  parameter int NUM_TIMERS = stlu_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [5:0]  in_timer_index,
  input  logic [31:0] in_delay,
  input  logic signed [31:0] in_tag_data,
  input  logic [7:0]  in_owner_id,
  input  logic        in_app_owned,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_out_index,
  output logic signed [31:0] out_out_data,
  output logic [7:0]  out_out_owner,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);
  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] LEND = LW'(NUM_TIMERS);

  typedef struct packed {
    logic [1:0]  mode;
    logic        app;
    logic [7:0]  owner;
    logic [31:0] tag;
    logic [31:0] expiry;
    logic [LW-1:0] link;
  } entry_t;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_RD    = 16'h0004,
    S_EVAL  = 16'h0008,
    S_SCAN  = 16'h0010,
    S_WALK  = 16'h0020,
    S_WALKE = 16'h0040,
    S_INS   = 16'h0080,
    S_INSE  = 16'h0100,
    S_TICK  = 16'h0200,
    S_TICKE = 16'h0400,
    S_ACK   = 16'h0800,
    S_HEADR = 16'h1000,
    S_HEADE = 16'h2000,
    S_FIN   = 16'h4000,
    S_TFIN  = 16'h8000
  } state_t;

  entry_t mem [NUM_TIMERS];
  entry_t rd_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  state_t state_r, state_nxt;
  logic [5:0]  task_idx_r;
  logic        task_en_r;
  logic [LW-1:0] head_r, head_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] early_r, early_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [7:0]  own_r, own_nxt;
  logic        app_r, app_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  entry_t      tgt_r, tgt_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [LW-1:0] aidx_r, aidx_nxt;
  logic        ins_r, ins_nxt;
  logic        scan_r, scan_nxt;
  logic        tfirst_r, tfirst_nxt;
  stlu_pkg::result_t pend_r, pend_nxt;

  logic push, full;
  stlu_pkg::result_t push_beat, out_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_idx_r <= '0;
      task_en_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == stlu_pkg::REG_TASK_INDEX) begin
        task_idx_r <= cfg_wdata;
      end else begin
        task_en_r <= cfg_wdata[0];
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      head_r  <= LEND;
      tick_r  <= '0;
      early_r <= stlu_pkg::ALL_ONES;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tick_r  <= tick_nxt;
      early_r <= early_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; idx_r <= idx_nxt; delay_r <= delay_nxt; tag_r <= tag_nxt;
    own_r <= own_nxt; app_r <= app_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt;
    tgt_r <= tgt_nxt; st_r <= st_nxt; aidx_r <= aidx_nxt; ins_r <= ins_nxt;
    scan_r <= scan_nxt; tfirst_r <= tfirst_nxt; pend_r <= pend_nxt;
  end

  // walk: unlink target (cur_r==target id idx_r) then optionally insert
  always_comb begin
    state_nxt = state_r; head_nxt = head_r; tick_nxt = tick_r; early_nxt = early_r;
    cnt_nxt = cnt_r; act_nxt = act_r; idx_nxt = idx_r; delay_nxt = delay_r;
    tag_nxt = tag_r; own_nxt = own_r; app_nxt = app_r; prev_nxt = prev_r;
    cur_nxt = cur_r; tgt_nxt = tgt_r; st_nxt = st_r; aidx_nxt = aidx_r;
    ins_nxt = ins_r; scan_nxt = scan_r; tfirst_nxt = tfirst_r; pend_nxt = pend_r;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    push = 1'b0; push_beat = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = cnt_r[IW-1:0];
        if (cnt_r == LEND - 1'b1) begin
          cnt_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action; idx_nxt = in_timer_index; delay_nxt = in_delay;
          tag_nxt = in_tag_data; own_nxt = in_owner_id; app_nxt = in_app_owned;
          st_nxt = stlu_pkg::ST_OK; aidx_nxt = '0; scan_nxt = 1'b0;
          cnt_nxt = '0;
          case (in_action)
            stlu_pkg::ACT_TICK: begin
              tick_nxt = tick_r + 32'd1;
              if (early_r <= tick_r + 32'd1) begin
                tfirst_nxt = 1'b1;
                state_nxt = S_TICK;
              end
            end
            stlu_pkg::ACT_ALLOC: begin
              scan_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
            stlu_pkg::ACT_FREE, stlu_pkg::ACT_INIT, stlu_pkg::ACT_SET: begin
              if ({1'b0, in_timer_index} >= 7'(NUM_TIMERS)) begin
                st_nxt = stlu_pkg::ST_NOT_ALLOC;
                state_nxt = S_ACK;
              end else begin
                state_nxt = S_RD;
              end
            end
            stlu_pkg::ACT_CANCEL: begin
              if (in_app_owned) begin
                scan_nxt = 1'b1;
                state_nxt = S_SCAN;
              end else if ({1'b0, in_timer_index} >= 7'(NUM_TIMERS)) begin
                st_nxt = stlu_pkg::ST_NOT_ALLOC;
                state_nxt = S_ACK;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        rd_addr = idx_r[IW-1:0];
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        tgt_nxt = rd_q;
        if (rd_q.mode == stlu_pkg::MODE_FREE) begin
          if (act_r == stlu_pkg::ACT_ALLOC || (act_r == stlu_pkg::ACT_CANCEL && app_r)) begin
            state_nxt = S_SCAN;
          end else begin
            st_nxt = stlu_pkg::ST_NOT_ALLOC;
            state_nxt = S_ACK;
          end
        end else if (act_r == stlu_pkg::ACT_ALLOC) begin
          state_nxt = S_SCAN;
        end else if (act_r == stlu_pkg::ACT_CANCEL && app_r) begin
          if (rd_q.app && rd_q.owner == own_r) begin
            tgt_nxt.mode = stlu_pkg::MODE_FREE;
            if (rd_q.mode == stlu_pkg::MODE_RUN) begin
              ins_nxt = 1'b0;
              prev_nxt = LEND;
              cur_nxt = head_r;
              state_nxt = S_WALK;
            end else begin
              wr_en = 1'b1; wr_addr = idx_r[IW-1:0]; wr_data = tgt_nxt;
              state_nxt = S_SCAN;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (act_r == stlu_pkg::ACT_INIT) begin
          tgt_nxt.owner = own_r; tgt_nxt.tag = tag_r; tgt_nxt.app = app_r;
          wr_en = 1'b1; wr_addr = idx_r[IW-1:0]; wr_data = tgt_nxt;
          state_nxt = S_ACK;
        end else if (act_r == stlu_pkg::ACT_CANCEL && rd_q.mode != stlu_pkg::MODE_RUN) begin
          st_nxt = stlu_pkg::ST_NOT_RUN;
          state_nxt = S_ACK;
        end else begin
          if (act_r == stlu_pkg::ACT_FREE) begin
            tgt_nxt.mode = stlu_pkg::MODE_FREE;
          end else begin
            tgt_nxt.mode = stlu_pkg::MODE_ALLOC;
          end
          ins_nxt = (act_r == stlu_pkg::ACT_SET);
          if (act_r == stlu_pkg::ACT_SET) begin
            tgt_nxt.expiry = delay_r + tick_r;
          end
          if (rd_q.mode == stlu_pkg::MODE_RUN) begin
            prev_nxt = LEND;
            cur_nxt = head_r;
            state_nxt = S_WALK;
          end else if (act_r == stlu_pkg::ACT_SET) begin
            prev_nxt = LEND;
            cur_nxt = head_r;
            state_nxt = S_INS;
          end else begin
            wr_en = 1'b1; wr_addr = idx_r[IW-1:0]; wr_data = tgt_nxt;
            state_nxt = S_ACK;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == LEND) begin
          if (act_r == stlu_pkg::ACT_ALLOC) begin
            st_nxt = stlu_pkg::ST_NO_FREE;
          end
          state_nxt = S_ACK;
        end else begin
          idx_nxt = 6'(cnt_r[IW-1:0]);
          if (act_r == stlu_pkg::ACT_ALLOC) begin
            rd_en = 1'b1; rd_addr = cnt_r[IW-1:0];
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (rd_q.mode == stlu_pkg::MODE_FREE) begin
          wr_en = 1'b1; wr_addr = idx_r[IW-1:0];
          wr_data = rd_q; wr_data.mode = stlu_pkg::MODE_ALLOC; wr_data.app = 1'b0;
          aidx_nxt = LW'(idx_r[IW-1:0]);
          state_nxt = S_ACK;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_WALK: begin
        if (cur_r == LW'(idx_r[IW-1:0])) begin
          // reached target: splice
          if (prev_r == LEND) begin
            head_nxt = tgt_r.link;
            if (ins_r) begin
              prev_nxt = LEND;
              cur_nxt = tgt_r.link;
              state_nxt = S_INS;
            end else begin
              wr_en = 1'b1; wr_addr = idx_r[IW-1:0]; wr_data = tgt_r;
              state_nxt = S_HEADR;
            end
          end else begin
            rd_en = 1'b1; rd_addr = prev_r[IW-1:0];
            state_nxt = S_WALKE;
          end
        end else begin
          rd_en = 1'b1; rd_addr = cur_r[IW-1:0];
          state_nxt = S_WALKE;
        end
      end
      S_WALKE: begin
        if (cur_r == LW'(idx_r[IW-1:0])) begin
          wr_en = 1'b1; wr_addr = prev_r[IW-1:0];
          wr_data = rd_q; wr_data.link = tgt_r.link;
          if (ins_r) begin
            prev_nxt = LEND;
            cur_nxt = head_r;
            state_nxt = S_INS;
          end else begin
            // write target next
            state_nxt = S_TFIN;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt = rd_q.link;
          state_nxt = S_WALK;
        end
      end
      S_TFIN: begin
        wr_en = 1'b1; wr_addr = idx_r[IW-1:0]; wr_data = tgt_r;
        state_nxt = S_HEADR;
      end
      S_INS: begin
        if (cur_r == LEND) begin
          tgt_nxt.link = LEND;
          state_nxt = S_INSE;
        end else begin
          rd_en = 1'b1; rd_addr = cur_r[IW-1:0];
          state_nxt = S_INSE;
        end
      end
      S_INSE: begin
        if (cur_r == LEND || tgt_r.expiry <= rd_q.expiry) begin
          wr_en = 1'b1; wr_addr = idx_r[IW-1:0];
          wr_data = tgt_r; wr_data.link = cur_r; wr_data.mode = stlu_pkg::MODE_RUN;
          tgt_nxt = wr_data;
          if (prev_r == LEND) begin
            head_nxt = LW'(idx_r[IW-1:0]);
            early_nxt = tgt_r.expiry;
            state_nxt = S_ACK;
          end else begin
            ins_nxt = 1'b0;
            state_nxt = S_HEADE;
          end
        end else begin
          tgt_nxt.link = rd_q.link;
          prev_nxt = cur_r;
          cur_nxt = rd_q.link;
          state_nxt = S_INS;
        end
      end
      S_HEADE: begin
        // patch predecessor link: read its contents here, write them back in S_HEADR
        rd_en = 1'b1; rd_addr = prev_r[IW-1:0];
        state_nxt = S_HEADR;
        ins_nxt = 1'b1;
      end
      S_HEADR: begin
        if (ins_r) begin
          wr_en = 1'b1; wr_addr = prev_r[IW-1:0];
          wr_data = rd_q; wr_data.link = LW'(idx_r[IW-1:0]);
          ins_nxt = 1'b0;
          state_nxt = S_HEADR;
        end else if (head_r == LEND) begin
          early_nxt = stlu_pkg::ALL_ONES;
          state_nxt = scan_r ? S_SCAN : S_ACK;
        end else begin
          rd_en = 1'b1; rd_addr = head_r[IW-1:0];
          state_nxt = S_TICKE;
          tfirst_nxt = 1'b0;
        end
      end
      S_TICK: begin
        if (full) begin
          state_nxt = S_TICK;
        end else if (head_r == LEND) begin
          early_nxt = stlu_pkg::ALL_ONES;
          if (!tfirst_r) begin
            pend_nxt.last = 1'b1;
            push = 1'b1; push_beat = pend_nxt;
          end
          state_nxt = S_IDLE;
        end else begin
          rd_en = 1'b1; rd_addr = head_r[IW-1:0];
          tfirst_nxt = tfirst_r;
          state_nxt = S_TICKE;
          ins_nxt = 1'b1;
        end
      end
      S_TICKE: begin
        if (!ins_r) begin
          // head refresh after unlink
          early_nxt = rd_q.expiry;
          state_nxt = scan_r ? S_SCAN : S_ACK;
        end else if (rd_q.expiry <= tick_r) begin
          if (!tfirst_r) begin
            push = 1'b1; push_beat = pend_r;
          end
          pend_nxt.kind = (task_en_r && head_r[IW-1:0] == task_idx_r[IW-1:0] &&
                           {1'b0, task_idx_r} < 7'(NUM_TIMERS))
                          ? stlu_pkg::KIND_TASK : stlu_pkg::KIND_EXP;
          pend_nxt.index = 6'(head_r[IW-1:0]);
          pend_nxt.data = rd_q.tag;
          pend_nxt.owner = rd_q.owner;
          pend_nxt.status = stlu_pkg::ST_OK;
          pend_nxt.last = 1'b0;
          wr_en = 1'b1; wr_addr = head_r[IW-1:0];
          wr_data = rd_q; wr_data.mode = stlu_pkg::MODE_ALLOC;
          head_nxt = rd_q.link;
          tfirst_nxt = 1'b0;
          state_nxt = S_TICK;
        end else begin
          early_nxt = rd_q.expiry;
          pend_nxt.last = 1'b1;
          push = 1'b1; push_beat = pend_nxt;
          state_nxt = S_IDLE;
        end
      end
      S_ACK: begin
        if (!full) begin
          push = 1'b1;
          push_beat.kind = stlu_pkg::KIND_ACK;
          push_beat.index = 6'(aidx_r);
          push_beat.status = st_r;
          push_beat.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  stlu_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  assign out_kind      = out_beat.kind;
  assign out_out_index = out_beat.index;
  assign out_out_data  = out_beat.data;
  assign out_out_owner = out_beat.owner;
  assign out_status    = out_beat.status;
  assign out_last      = out_beat.last;

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("busy but not stalling");
  a_head_early: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && head_r == LEND) |-> (early_r == stlu_pkg::ALL_ONES))
    else $error("empty list with finite earliest expiry");
  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("result pushed into full output register");
`endif
endmodule
